[hdl/assert_macros.svh]
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every edge out of reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

[hdl/pdfm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package pdfm_pkg;

	localparam int TIMER_WIDTH   = 16;
	localparam int CAPTURE_WIDTH = 16;
	localparam int DUTY_WIDTH    = 7;
	localparam int FREQ_WIDTH    = 27;
	localparam int CLK_HZ_WIDTH  = 27;
	localparam int SCALE_WIDTH   = 7;
	localparam int PROD_WIDTH    = TIMER_WIDTH + SCALE_WIDTH;
	localparam int DIV_WIDTH     = (PROD_WIDTH > CLK_HZ_WIDTH) ? PROD_WIDTH : CLK_HZ_WIDTH;
	localparam int CNT_WIDTH     = $clog2(DIV_WIDTH + 1);
	localparam int APB_ADDR_WIDTH = 3;
	localparam int APB_DATA_WIDTH = 32;

	localparam logic [SCALE_WIDTH-1:0]  PERCENT_SCALE  = SCALE_WIDTH'(100);
	localparam logic [CLK_HZ_WIDTH-1:0] CLOCK_HZ_RESET = CLK_HZ_WIDTH'(8000000);

	// register index, taken from the word address
	localparam logic REG_CLOCK_HZ = 1'b0;

	typedef enum logic [1:0] {
		PH_RISE0 = 2'd0,
		PH_FALL  = 2'd1,
		PH_RISE1 = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		B_IDLE = 2'd0,
		B_DUTY = 2'd1,
		B_FREQ = 2'd2,
		B_DONE = 2'd3
	} back_state_t;

	typedef struct packed {
		logic [TIMER_WIDTH-1:0] high;
		logic [TIMER_WIDTH-1:0] period;
		logic                   valid;
	} job_t;

endpackage
`default_nettype wire

[hdl/pdfm_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module pdfm_front
	import pdfm_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     accept,
	input  wire logic [CAPTURE_WIDTH-1:0] capture_time,
	output logic                          job_push,
	output job_t                          job
);

	phase_t                 phase_q;
	logic [TIMER_WIDTH-1:0] rise_q;
	logic [TIMER_WIDTH-1:0] fall_q;
	logic [TIMER_WIDTH-1:0] t;

	assign t = TIMER_WIDTH'(capture_time);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RISE0;
		end else if (accept) begin
			unique case (phase_q)
				PH_FALL:  phase_q <= PH_RISE1;
				PH_RISE1: phase_q <= PH_RISE0;
				default:  phase_q <= PH_FALL;
			endcase
		end
	end

	// stamps carry no reset, each is written before it is read
	always_ff @(posedge clk) begin
		if (accept) begin
			if (phase_q == PH_FALL) begin
				fall_q <= t;
			end else if (phase_q != PH_RISE1) begin
				rise_q <= t;
			end
		end
	end

	assign job_push   = accept && (phase_q == PH_RISE1);
	assign job.valid  = (rise_q < fall_q) && (fall_q < t);
	assign job.high   = fall_q - rise_q;
	assign job.period = t - rise_q;

endmodule
`default_nettype wire

[hdl/pdfm_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module pdfm_queue
	import pdfm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      din,
	output logic      full,
	input  wire logic pop,
	output logic      empty,
	output job_t      dout
);

	// two-entry queue: head is the oldest job
	job_t head_q;
	job_t tail_q;
	logic head_vld_q;
	logic tail_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			tail_vld_q <= 1'b0;
		end else if (pop) begin
			if (tail_vld_q) begin
				tail_vld_q <= push;
			end else begin
				head_vld_q <= push;
			end
		end else if (push) begin
			if (head_vld_q) begin
				tail_vld_q <= 1'b1;
			end else begin
				head_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (tail_vld_q) begin
				head_q <= tail_q;
				if (push) begin
					tail_q <= din;
				end
			end else if (push) begin
				head_q <= din;
			end
		end else if (push) begin
			if (head_vld_q) begin
				tail_q <= din;
			end else begin
				head_q <= din;
			end
		end
	end

	assign full  = tail_vld_q;
	assign empty = !head_vld_q;
	assign dout  = head_q;

endmodule
`default_nettype wire

[hdl/pdfm_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module pdfm_back
	import pdfm_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [CLK_HZ_WIDTH-1:0] clock_hz,
	input  wire logic                    q_empty,
	input  job_t                         q_job,
	output logic                         q_pop,
	output logic                         empty,
	input  wire logic                    pop,
	output logic [DUTY_WIDTH-1:0]        duty_percent,
	output logic [FREQ_WIDTH-1:0]        frequency_hz,
	output logic                         measure_valid
);

	back_state_t state_q, state_d;

	logic [DIV_WIDTH-1:0]   dvd_q;
	logic [TIMER_WIDTH-1:0] dvs_q;
	logic [TIMER_WIDTH-1:0] rem_q;
	logic [CNT_WIDTH-1:0]   cnt_q;
	logic [DUTY_WIDTH-1:0]  duty_q;
	logic [FREQ_WIDTH-1:0]  freq_q;
	logic                   vld_q;
	logic                   out_full_q;

	logic [PROD_WIDTH-1:0]  prod;
	logic [TIMER_WIDTH:0]   rem_sh;
	logic [TIMER_WIDTH:0]   diff;
	logic                   ge;
	logic [TIMER_WIDTH-1:0] rem_next;
	logic [DIV_WIDTH-1:0]   dvd_next;
	logic                   last_step;
	logic                   load_out;

	// one restoring division step per cycle
	assign prod     = PROD_WIDTH'(q_job.high) * PROD_WIDTH'(PERCENT_SCALE);
	assign rem_sh   = {rem_q, dvd_q[DIV_WIDTH-1]};
	assign diff     = rem_sh - {1'b0, dvs_q};
	assign ge       = (rem_sh >= {1'b0, dvs_q});
	assign rem_next = ge ? diff[TIMER_WIDTH-1:0] : rem_sh[TIMER_WIDTH-1:0];
	assign dvd_next = {dvd_q[DIV_WIDTH-2:0], ge};
	assign last_step = (cnt_q == CNT_WIDTH'(1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (!q_empty) state_d = q_job.valid ? B_DUTY : B_DONE;
			B_DUTY: if (last_step) state_d = B_FREQ;
			B_FREQ: if (last_step) state_d = B_DONE;
			B_DONE: if (!out_full_q || pop) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = (state_q == B_IDLE) && !q_empty;
		load_out = (state_q == B_DONE) && (!out_full_q || pop);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_full_q <= 1'b1;
			end else if (pop) begin
				out_full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			dvd_q  <= DIV_WIDTH'(prod);
			dvs_q  <= q_job.period;
			rem_q  <= '0;
			cnt_q  <= CNT_WIDTH'(DIV_WIDTH);
			vld_q  <= q_job.valid;
			duty_q <= '0;
			freq_q <= '0;
		end else if (state_q == B_DUTY) begin
			if (last_step) begin
				duty_q <= dvd_next[DUTY_WIDTH-1:0];
				dvd_q  <= DIV_WIDTH'(clock_hz);
				rem_q  <= '0;
				cnt_q  <= CNT_WIDTH'(DIV_WIDTH);
			end else begin
				dvd_q <= dvd_next;
				rem_q <= rem_next;
				cnt_q <= cnt_q - CNT_WIDTH'(1);
			end
		end else if (state_q == B_FREQ) begin
			dvd_q <= dvd_next;
			rem_q <= rem_next;
			cnt_q <= cnt_q - CNT_WIDTH'(1);
			if (last_step) begin
				freq_q <= dvd_next[FREQ_WIDTH-1:0];
			end
		end
		if (load_out) begin
			duty_percent  <= duty_q;
			frequency_hz  <= freq_q;
			measure_valid <= vld_q;
		end
	end

	assign empty = !out_full_q;

endmodule
`default_nettype wire

[hdl/pwm_duty_freq_meter.sv]
// pwm duty and frequency meter from input-capture timestamps
// a result follows the transaction of the third capture through the job queue, the queue pop,
// 27 + 27 restoring-divider steps and the output load; an invalid triple skips the divider steps
// throughput: one result per third capture; the back end works on one job at a time, and
// a two-deep job queue lets the capture side keep taking transactions while the queue has room
// reset: arst_n async low clears phase, queue, back-end state and output slot; clock_hz -> 8000000
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pwm_duty_freq_meter
	import pdfm_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// capture side
	input  wire logic                      push,
	output logic                           full,
	input  wire logic [CAPTURE_WIDTH-1:0]  capture_time,
	// result side
	output logic                           empty,
	input  wire logic                      pop,
	output logic [DUTY_WIDTH-1:0]          duty_percent,
	output logic [FREQ_WIDTH-1:0]          frequency_hz,
	output logic                           measure_valid,
	// configuration
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [APB_ADDR_WIDTH-1:0] paddr,
	input  wire logic [APB_DATA_WIDTH-1:0] pwdata,
	output logic [APB_DATA_WIDTH-1:0]      prdata,
	output logic                           pready
);

	logic [CLK_HZ_WIDTH-1:0] clock_hz_q;
	logic                    accept;
	logic                    job_push;
	job_t                    job_in;
	job_t                    job_out;
	logic                    q_empty;
	logic                    q_pop;
	logic                    cfg_wr;

	// register file: one word, clock_hz at byte address 0
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= CLOCK_HZ_RESET;
		end else if (cfg_wr && (paddr[2] == REG_CLOCK_HZ)) begin
			clock_hz_q <= pwdata[CLK_HZ_WIDTH-1:0];
		end
	end

	// reads of addresses past the register return zero
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_CLOCK_HZ) begin
			prdata = APB_DATA_WIDTH'(clock_hz_q);
		end
	end

	// a capture transaction goes in whenever the job queue has room
	assign accept = push && !full;

	// front end: phase tracking, stamp storage, ordering check
	pdfm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.capture_time (capture_time),
		.job_push     (job_push),
		.job          (job_in)
	);

	// decouples the capture side from the divider
	pdfm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.full   (full),
		.pop    (q_pop),
		.empty  (q_empty),
		.dout   (job_out)
	);

	// back end: duty and frequency divisions, output slot
	pdfm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.clock_hz      (clock_hz_q),
		.q_empty       (q_empty),
		.q_job         (job_out),
		.q_pop         (q_pop),
		.empty         (empty),
		.pop           (pop),
		.duty_percent  (duty_percent),
		.frequency_hz  (frequency_hz),
		.measure_valid (measure_valid)
	);

	// an invalid measurement carries all-zero fields
	`ASSERT_IMPL(a_invalid_zero, !empty && !measure_valid, duty_percent == '0 && frequency_hz == '0, "invalid result with nonzero fields")
	// duty of a valid measurement stays below one hundred percent
	`ASSERT_IMPL(a_duty_range, !empty && measure_valid, duty_percent < DUTY_WIDTH'(100), "duty out of range")
	// jobs only enter the queue from an accepted capture transaction
	`ASSERT_IMPL(a_push_accept, job_push, push && !full, "job pushed without a capture transaction")

endmodule
`default_nettype wire
